/* rtl/chm_pkg.sv */
// Shared constants and types for the chained hash map engine.
// No dependencies; every other file refers to it by scoped names.
package chm_pkg;

	// Field widths of the request and response items.
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned HASH_W  = 32;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned COUNT_W = 11;

	typedef logic [CMD_W-1:0] cmd_t;

	// Command codes.
	localparam cmd_t CMD_FIND   = 3'd0;
	localparam cmd_t CMD_WRITE  = 3'd1;
	localparam cmd_t CMD_FETCH  = 3'd2;
	localparam cmd_t CMD_REMOVE = 3'd3;
	localparam cmd_t CMD_CLEAR  = 3'd4;

	// Response status codes.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

endpackage

/* rtl/chm_if.sv */
// Request and response channel interfaces of the chained hash map engine.
// Depends on chm_pkg for the field widths.
interface chm_req_if;
	logic                        valid;
	logic                        ready;
	logic [chm_pkg::CMD_W-1:0]   command;
	logic [chm_pkg::KEY_W-1:0]   key;
	logic [chm_pkg::HASH_W-1:0]  key_hash;
	logic [chm_pkg::VAL_W-1:0]   write_value;

	modport source (output valid, command, key, key_hash, write_value, input ready);
	modport sink   (input valid, command, key, key_hash, write_value, output ready);
endinterface

interface chm_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [chm_pkg::VAL_W-1:0]   read_value;
	logic [chm_pkg::COUNT_W-1:0] live_count;
	logic                        status;

	modport source (output valid, found, read_value, live_count, status, input ready);
	modport sink   (input valid, found, read_value, live_count, status, output ready);
endinterface

/* rtl/chm_bin_unit.sv */
// Bin selection: key hash modulo the number of bins.
// Depends on chm_pkg. A mask for a power-of-two bin count, else a reciprocal multiplication.
module chm_bin_unit #(
	parameter int unsigned NUM_BINS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [chm_pkg::HASH_W-1:0]        hash,
	output logic                              done,
	output logic [(NUM_BINS > 1 ? $clog2(NUM_BINS) : 1)-1:0] bin
);

	localparam int unsigned BIN_W  = NUM_BINS > 1 ? $clog2(NUM_BINS) : 1;
	localparam bit          IS_POW2 = (NUM_BINS & (NUM_BINS - 1)) == 0;

	generate
		if (IS_POW2) begin : g_mask
			logic             done_q;
			logic [BIN_W-1:0] bin_q;

			// The low hash bits are the bin; a single bin always maps to zero.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					bin_q <= (NUM_BINS > 1) ? hash[BIN_W-1:0] : '0;
				end
			end

			assign done = done_q;
			assign bin  = bin_q;
		end else begin : g_recip
			// The quotient is the hash times a 33-bit reciprocal, shifted down; it is
			// exact for every 32-bit hash. The remainder needs only its low bits.
			localparam int unsigned SH = chm_pkg::HASH_W + BIN_W;
			localparam logic [63:0] RECIP = ((64'd1 << SH) / 64'(NUM_BINS)) + 64'd1;
			localparam logic [16:0] M_LO = RECIP[16:0];
			localparam logic [15:0] M_HI = RECIP[32:17];
			localparam logic [BIN_W-1:0] NB = BIN_W'(NUM_BINS);

			logic                         valid_s1;
			logic                         valid_s2;
			logic                         done_q;
			logic [chm_pkg::HASH_W+16:0]  p_lo_s1;
			logic [chm_pkg::HASH_W+15:0]  p_hi_s1;
			logic [chm_pkg::HASH_W-1:0]   hash_s1;
			logic [chm_pkg::HASH_W-1:0]   hash_s2;
			logic [chm_pkg::HASH_W+32:0]  prod;
			logic [BIN_W-1:0]             quot_s2;
			logic [BIN_W-1:0]             qn;
			logic [BIN_W-1:0]             rem_q;

			assign prod = {p_hi_s1, 17'b0} + {16'b0, p_lo_s1};
			assign qn   = quot_s2 * NB;

			// Three stages: partial products, quotient, remainder.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s1 <= 1'b0;
					valid_s2 <= 1'b0;
					done_q   <= 1'b0;
				end else begin
					valid_s1 <= start;
					valid_s2 <= valid_s1;
					done_q   <= valid_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					hash_s1 <= hash;
					p_lo_s1 <= (chm_pkg::HASH_W+17)'(hash) * (chm_pkg::HASH_W+17)'(M_LO);
					p_hi_s1 <= (chm_pkg::HASH_W+16)'(hash) * (chm_pkg::HASH_W+16)'(M_HI);
				end
				if (valid_s1) begin
					hash_s2 <= hash_s1;
					quot_s2 <= prod[SH +: BIN_W];
				end
				if (valid_s2) begin
					rem_q <= hash_s2[BIN_W-1:0] - qn;
				end
			end

			assign done = done_q;
			assign bin  = rem_q;
		end
	endgenerate

endmodule

/* rtl/chained_hash_map_engine_top.sv */
// Chained hash map engine: a key/value store with separate chaining. One request at a time
// is served. A clear goes from acceptance straight to the response load. Any other command
// passes through the bin selection (a mask, or the reciprocal stages when NUM_BINS is not a
// power of two), the bin head read, one entry memory read per chain entry visited, the update
// and the response load. A finished response waits in its output register while the
// next request is accepted. Depends on chm_pkg, chm_if and chm_bin_unit.
module chained_hash_map_engine_top #(
	parameter int unsigned NUM_BINS    = 256,
	parameter int unsigned NUM_ENTRIES = 1024,
	parameter int unsigned KEY_BITS    = 32,
	parameter int unsigned VALUE_BITS  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	chm_req_if.sink    req,
	chm_rsp_if.source  rsp
);

	localparam int unsigned BIN_W  = NUM_BINS > 1 ? $clog2(NUM_BINS) : 1;
	localparam int unsigned IDX_W  = $clog2(NUM_ENTRIES + 1);
	localparam int unsigned ADDR_W = NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1;
	localparam int unsigned KW     = KEY_BITS < chm_pkg::KEY_W ? KEY_BITS : chm_pkg::KEY_W;
	localparam int unsigned VW     = VALUE_BITS < chm_pkg::VAL_W ? VALUE_BITS : chm_pkg::VAL_W;
	localparam logic [IDX_W-1:0] EMPTY_LINK = IDX_W'(NUM_ENTRIES);

	typedef enum logic [2:0] {S_IDLE, S_BIN, S_HEAD, S_ENT, S_ACT, S_DONE} state_t;

	state_t                     state_q;
	chm_pkg::cmd_t              cmd_q;
	logic [KW-1:0]              key_q;
	logic [chm_pkg::HASH_W-1:0] hash_q;
	logic [VW-1:0]              wval_q;
	logic [BIN_W-1:0]           bin_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       hit_q;
	logic [IDX_W-1:0]           used_q;
	logic [IDX_W-1:0]           removed_q;
	logic                       out_valid_q;
	logic                       out_found_q;
	logic [VW-1:0]              out_val_q;
	logic [chm_pkg::COUNT_W-1:0] out_count_q;
	logic                       out_status_q;
	logic                       res_found_q;
	logic [VW-1:0]              res_val_q;
	logic                       res_status_q;

	logic                       accept;
	logic                       bin_done;
	logic [BIN_W-1:0]           bin_sel;

	// Bin head store: memory plus one valid flag per bin, cleared at once.
	logic [IDX_W-1:0]           head_mem [NUM_BINS];
	logic [NUM_BINS-1:0]        head_vld_q;
	logic [IDX_W-1:0]           head_rd_q;
	logic                       head_vld_rd_q;
	logic                       head_re;
	logic                       head_we;
	logic [IDX_W-1:0]           head_link;

	// Entry store: one memory per field, all sharing address and write enable.
	logic [KW-1:0]              ent_key_mem  [NUM_ENTRIES];
	logic [chm_pkg::HASH_W-1:0] ent_hash_mem [NUM_ENTRIES];
	logic [VW-1:0]              ent_val_mem  [NUM_ENTRIES];
	logic [IDX_W-1:0]           ent_next_mem [NUM_ENTRIES];
	logic                       ent_rem_mem  [NUM_ENTRIES];
	logic [KW-1:0]              e_key_q;
	logic [chm_pkg::HASH_W-1:0] e_hash_q;
	logic [VW-1:0]              e_val_q;
	logic [IDX_W-1:0]           e_next_q;
	logic                       e_rem_q;
	logic                       ent_re;
	logic [ADDR_W-1:0]          ent_raddr;
	logic                       ent_we;
	logic [ADDR_W-1:0]          ent_waddr;
	logic [KW-1:0]              w_key;
	logic [chm_pkg::HASH_W-1:0] w_hash;
	logic [VW-1:0]              w_val;
	logic [IDX_W-1:0]           w_next;
	logic                       w_rem;

	// Update decisions made in the action state.
	logic                       live;
	logic                       ent_match;
	logic [VW-1:0]              newval;
	logic                       act_we;
	logic                       used_inc;
	logic                       rem_inc;
	logic                       rem_dec;
	logic                       a_found;
	logic [VW-1:0]              a_val;
	logic                       a_status;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	chm_bin_unit #(
		.NUM_BINS (NUM_BINS)
	) u_bin (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (req.command != chm_pkg::CMD_CLEAR)),
		.hash   (req.key_hash),
		.done   (bin_done),
		.bin    (bin_sel)
	);

	assign head_link = head_vld_rd_q ? head_rd_q : EMPTY_LINK;
	assign ent_match = (e_hash_q == hash_q) && (e_key_q == key_q);

	// Chain walk read control.
	always_comb begin
		ent_re    = 1'b0;
		ent_raddr = head_link[ADDR_W-1:0];
		head_re   = (state_q == S_BIN) && bin_done;
		if (state_q == S_HEAD) begin
			ent_re    = head_link < used_q;
			ent_raddr = head_link[ADDR_W-1:0];
		end else if (state_q == S_ENT) begin
			ent_re    = !ent_match && (e_next_q < used_q);
			ent_raddr = e_next_q[ADDR_W-1:0];
		end
	end

	// Update of the matched or newly allocated entry.
	always_comb begin
		live      = hit_q && !e_rem_q;
		newval    = (cmd_q == chm_pkg::CMD_WRITE) ? wval_q : '0;
		act_we    = 1'b0;
		ent_waddr = idx_q[ADDR_W-1:0];
		w_key     = e_key_q;
		w_hash    = e_hash_q;
		w_val     = e_val_q;
		w_next    = e_next_q;
		w_rem     = e_rem_q;
		head_we   = 1'b0;
		used_inc  = 1'b0;
		rem_inc   = 1'b0;
		rem_dec   = 1'b0;
		a_found   = live;
		a_val     = '0;
		a_status  = chm_pkg::STATUS_OK;
		case (cmd_q)
			chm_pkg::CMD_WRITE, chm_pkg::CMD_FETCH: begin
				if (live) begin
					if (cmd_q == chm_pkg::CMD_WRITE) begin
						act_we = 1'b1;
						w_val  = wval_q;
						a_val  = wval_q;
					end else begin
						a_val = e_val_q;
					end
				end else if (hit_q) begin
					// A removed entry comes back with the new value.
					act_we  = 1'b1;
					w_rem   = 1'b0;
					w_val   = newval;
					rem_dec = removed_q != '0;
					a_val   = newval;
				end else if (used_q < EMPTY_LINK) begin
					// Allocate the next free entry and link it at the chain head.
					act_we    = 1'b1;
					ent_waddr = used_q[ADDR_W-1:0];
					w_key     = key_q;
					w_hash    = hash_q;
					w_val     = newval;
					w_next    = head_link;
					w_rem     = 1'b0;
					head_we   = 1'b1;
					used_inc  = 1'b1;
					a_val     = newval;
				end else begin
					a_status = chm_pkg::STATUS_FULL;
				end
			end
			chm_pkg::CMD_REMOVE: begin
				if (live) begin
					act_we  = 1'b1;
					w_rem   = 1'b1;
					rem_inc = 1'b1;
				end
			end
			default: begin
				a_val = live ? e_val_q : '0;
			end
		endcase
		ent_we = act_we && (state_q == S_ACT);
	end

	// Bin head memory with registered read.
	always_ff @(posedge clk) begin
		if (head_we && (state_q == S_ACT)) begin
			head_mem[bin_q] <= used_q;
		end
		if (head_re) begin
			head_rd_q <= head_mem[bin_sel];
		end
	end

	// Per-bin valid flags; clear empties every bin at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q    <= '0;
			head_vld_rd_q <= 1'b0;
		end else begin
			if (accept && (req.command == chm_pkg::CMD_CLEAR)) begin
				head_vld_q <= '0;
			end else if (head_we && (state_q == S_ACT)) begin
				head_vld_q[bin_q] <= 1'b1;
			end
			if (head_re) begin
				head_vld_rd_q <= head_vld_q[bin_sel];
			end
		end
	end

	// Entry memories with registered read.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_key_mem[ent_waddr]  <= w_key;
			ent_hash_mem[ent_waddr] <= w_hash;
			ent_val_mem[ent_waddr]  <= w_val;
			ent_next_mem[ent_waddr] <= w_next;
			ent_rem_mem[ent_waddr]  <= w_rem;
		end
		if (ent_re) begin
			e_key_q  <= ent_key_mem[ent_raddr];
			e_hash_q <= ent_hash_mem[ent_raddr];
			e_val_q  <= ent_val_mem[ent_raddr];
			e_next_q <= ent_next_mem[ent_raddr];
			e_rem_q  <= ent_rem_mem[ent_raddr];
		end
	end

	// Request fields captured on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.command;
			key_q  <= req.key[KW-1:0];
			hash_q <= req.key_hash;
			wval_q <= req.write_value[VW-1:0];
		end
		if (state_q == S_BIN && bin_done) begin
			bin_q <= bin_sel;
		end
	end

	// Sequencer: bin, head read, chain walk, update, response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			hit_q        <= 1'b0;
			used_q       <= '0;
			removed_q    <= '0;
			res_found_q  <= 1'b0;
			res_val_q    <= '0;
			res_status_q <= chm_pkg::STATUS_OK;
			out_valid_q  <= 1'b0;
			out_found_q  <= 1'b0;
			out_val_q    <= '0;
			out_count_q  <= '0;
			out_status_q <= chm_pkg::STATUS_OK;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command == chm_pkg::CMD_CLEAR) begin
							used_q       <= '0;
							removed_q    <= '0;
							res_found_q  <= 1'b0;
							res_val_q    <= '0;
							res_status_q <= chm_pkg::STATUS_OK;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_BIN;
						end
					end
				end
				S_BIN: begin
					if (bin_done) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					idx_q <= head_link;
					hit_q <= 1'b0;
					state_q <= (head_link < used_q) ? S_ENT : S_ACT;
				end
				S_ENT: begin
					if (ent_match) begin
						hit_q   <= 1'b1;
						state_q <= S_ACT;
					end else if (e_next_q < used_q) begin
						idx_q <= e_next_q;
					end else begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (used_inc) begin
						used_q <= used_q + 1'b1;
					end
					if (rem_inc) begin
						removed_q <= removed_q + 1'b1;
					end else if (rem_dec) begin
						removed_q <= removed_q - 1'b1;
					end
					res_found_q  <= a_found;
					res_val_q    <= a_val;
					res_status_q <= a_status;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// Wait for the output register to free up; the live count is
					// captured with the item so that it holds while the item waits.
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_found_q  <= res_found_q;
						out_val_q    <= res_val_q;
						out_count_q  <= chm_pkg::COUNT_W'(used_q - removed_q);
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.found      = out_found_q;
	assign rsp.read_value = chm_pkg::VAL_W'(out_val_q);
	assign rsp.live_count = out_count_q;
	assign rsp.status     = out_status_q;

`ifndef NO_ASSERTIONS
	a_removed_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		removed_q <= used_q) else $error("removed count exceeds allocated count");

	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= EMPTY_LINK) else $error("allocated count exceeds entry store");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.command == chm_pkg::CMD_CLEAR) |=> (used_q == '0) && (removed_q == '0))
		else $error("clear did not empty the store");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ENT |-> idx_q < used_q) else $error("chain walk left allocated entries");
`endif

endmodule
